[rtl/mrwc_pkg.sv]
// Package with shared types and constants for the Miller-Rabin witness check.
package mrwc_pkg;
  localparam int WORD_BITS_DEF = 64;

  localparam logic [2:0] VERDICT_NO_WITNESS = 3'd0;
  localparam logic [2:0] VERDICT_ROOT       = 3'd1;
  localparam logic [2:0] VERDICT_FERMAT     = 3'd2;
  localparam logic [2:0] VERDICT_TRIVIAL    = 3'd3;
  localparam logic [2:0] VERDICT_TWO        = 3'd4;
  localparam logic [2:0] VERDICT_BAD_BASE   = 3'd5;

  typedef struct packed {
    logic [63:0] candidate;
    logic [63:0] base;
  } in_item_t;

  typedef struct packed {
    logic [2:0] verdict;
    logic       probably_prime;
  } out_item_t;
endpackage

[rtl/mrwc_mulmod.sv]
// Bit-serial modular multiplier: one multiplier bit per cycle, double and add mod m.
module mrwc_mulmod #(
  parameter int WORD_BITS = mrwc_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] x,
  input  logic [WORD_BITS-1:0] y,
  input  logic [WORD_BITS-1:0] m,
  output logic                 done,
  output logic [WORD_BITS-1:0] prod
);
  localparam int CW = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] acc_r, acc_nxt, y_r, y_nxt, x_r, m_r;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 run_r, run_nxt, done_r, done_nxt;
  logic [WORD_BITS:0]   dbl, dbl_red, sum, sum_red;

  always_comb begin
    // Doubling and adding stay below 2m, so one compare-subtract reduces each.
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum     = dbl_red + {1'b0, x_r};
    sum_red = (sum >= {1'b0, m_r}) ? sum - {1'b0, m_r} : sum;
    acc_nxt  = acc_r;
    y_nxt    = y_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0;
      y_nxt   = y;
      cnt_nxt = CW'(WORD_BITS);
      run_nxt = 1'b1;
    end else if (run_r) begin
      acc_nxt = y_r[WORD_BITS-1] ? sum_red[WORD_BITS-1:0] : dbl_red[WORD_BITS-1:0];
      y_nxt   = {y_r[WORD_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    y_r   <= y_nxt;
    if (start) begin
      x_r <= x;
      m_r <= m;
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

[rtl/miller_rabin_witness_check_top.sv]
// Top level of the Miller-Rabin witness check: one round per transfer.
// Flow: trivial cases and bad bases go from S_CHECK straight to S_DONE, which raises the
// strobe; a full round strips the factors of two of n-1 at one per cycle, then runs up to
// about 2*W modular multiplications on the bit-serial multiplier, where W is WORD_BITS.
// One item at a time: busy stays high through the result strobe cycle; the receiver cannot
// stall. Reset (rst_n low, synchronous) returns the sequencer to idle and drops the strobe.
module miller_rabin_witness_check_top #(
  parameter int WORD_BITS = mrwc_pkg::WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mrwc_pkg::in_item_t  in_item,
  output logic                out_valid,
  output mrwc_pkg::out_item_t out_item
);
  localparam int TW = $clog2(WORD_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_STRIP, S_POW_STEP, S_POW_MUL, S_POW_SQR, S_SQR, S_DONE
  } state_t;

  state_t               state_r;
  logic [WORD_BITS-1:0] n_r, a_r, e_r, r_r, b_r;
  logic [TW-1:0]        t_r;
  logic [2:0]           verdict_r;
  logic                 out_valid_r;
  logic                 mm_kick_r;
  logic                 mm_start;
  logic [WORD_BITS-1:0] mm_x, mm_y, mm_prod, n_m1;
  logic                 mm_done;

  assign n_m1 = n_r - WORD_BITS'(1);

  // The multiplier always squares or multiplies the working values. The operands are
  // captured in the cycle after the kick, when the state already names the operation.
  always_comb begin
    mm_x = r_r;
    mm_y = b_r;
    if (state_r == S_POW_SQR) begin
      mm_x = b_r;
      mm_y = b_r;
    end else if (state_r == S_SQR) begin
      mm_x = r_r;
      mm_y = r_r;
    end
  end

  assign mm_start = mm_kick_r;

  mrwc_mulmod #(.WORD_BITS(WORD_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mm_start), .x(mm_x), .y(mm_y), .m(n_r),
    .done(mm_done), .prod(mm_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mm_kick_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      mm_kick_r   <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start && !busy) begin
            n_r     <= in_item.candidate[WORD_BITS-1:0];
            a_r     <= in_item.base[WORD_BITS-1:0];
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (n_r == WORD_BITS'(2)) begin
            verdict_r <= mrwc_pkg::VERDICT_TWO;
            state_r   <= S_DONE;
          end else if (!n_r[0] || n_r == WORD_BITS'(1)) begin
            verdict_r <= mrwc_pkg::VERDICT_TRIVIAL;
            state_r   <= S_DONE;
          end else if (a_r < WORD_BITS'(2) || a_r > n_m1) begin
            verdict_r <= mrwc_pkg::VERDICT_BAD_BASE;
            state_r   <= S_DONE;
          end else begin
            // n-1 is even here, so one factor of two comes off at once.
            e_r     <= n_m1 >> 1;
            t_r     <= TW'(1);
            r_r     <= WORD_BITS'(1);
            b_r     <= a_r;
            state_r <= S_STRIP;
          end
        end
        S_STRIP: begin
          // Strip one trailing zero per cycle until the odd part u remains.
          if (!e_r[0]) begin
            e_r <= e_r >> 1;
            t_r <= t_r + TW'(1);
          end else begin
            state_r <= S_POW_STEP;
          end
        end
        S_POW_STEP: begin
          // Square-and-multiply on u, lowest exponent bit first; once u is used up, square r instead.
          mm_kick_r <= 1'b1;
          if (e_r == '0) begin
            state_r <= S_SQR;
          end else if (e_r[0]) begin
            state_r <= S_POW_MUL;
          end else begin
            state_r <= S_POW_SQR;
          end
        end
        S_POW_MUL: begin
          if (mm_done) begin
            r_r       <= mm_prod;
            state_r   <= S_POW_SQR;
            mm_kick_r <= 1'b1;
          end
        end
        S_POW_SQR: begin
          if (mm_done) begin
            b_r     <= mm_prod;
            e_r     <= e_r >> 1;
            state_r <= S_POW_STEP;
          end
        end
        S_SQR: begin
          if (mm_done) begin
            if (mm_prod == WORD_BITS'(1) && r_r != WORD_BITS'(1) && r_r != n_m1) begin
              verdict_r <= mrwc_pkg::VERDICT_ROOT;
              state_r   <= S_DONE;
            end else if (t_r == TW'(1)) begin
              // The last square is a^(n-1); anything but 1 fails Fermat.
              verdict_r <= (mm_prod != WORD_BITS'(1)) ? mrwc_pkg::VERDICT_FERMAT
                                                      : mrwc_pkg::VERDICT_NO_WITNESS;
              state_r   <= S_DONE;
            end else begin
              r_r       <= mm_prod;
              t_r       <= t_r - TW'(1);
              mm_kick_r <= 1'b1;
            end
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_item.verdict = verdict_r;
  assign out_item.probably_prime = (verdict_r == mrwc_pkg::VERDICT_NO_WITNESS) ||
                                   (verdict_r == mrwc_pkg::VERDICT_TWO);

  // A result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  // Nothing is taken while a result is pending.
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("busy low with result");
  // A verdict is always one of the six defined codes.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.verdict <= mrwc_pkg::VERDICT_BAD_BASE))
    else $error("undefined verdict");
endmodule
